### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the compensation datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, skipped while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types and constants for the sensor compensation pipeline
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int unsigned CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CAL_TEMP    = 3'd0,
      CSR_CAL_PRESS_A = 3'd1,
      CSR_CAL_PRESS_B = 3'd2,
      CSR_CAL_PRESS_C = 3'd3,
      CSR_CAL_HUM_A   = 3'd4,
      CSR_CAL_HUM_B   = 3'd5
   } csr_idx_type;

   localparam logic [31:0] K64000   = 32'd64000;
   localparam logic [31:0] K1M      = 32'd1048576;
   localparam logic [31:0] K3125    = 32'd3125;
   localparam logic [31:0] KSIGN    = 32'h8000_0000;
   localparam logic [31:0] K76800   = 32'd76800;
   localparam logic [31:0] KHUMMAX  = 32'd419430400;
   localparam logic [31:0] K16384   = 32'd16384;
   localparam logic [31:0] K2097152 = 32'd2097152;
   localparam logic [31:0] K32768   = 32'd32768;
   localparam logic [31:0] K8192    = 32'd8192;

   // calibration, sign or zero extended to 32 bits
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } cal_type;

   // 32-bit wrapping product
   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

endpackage

### rtl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// fixed-point temperature, pressure and humidity compensation pipeline
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data fields (low bit first)
//  req     | in  | adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
//  rsp     | out | temperature_centi[31:0], pressure_pa[63:32],
//          |     | humidity_q10[80:64]; tuser = pressure_invalid
//  csr     | in  | csr_index selects register, csr_data write value
//
// one transaction per cycle sustained when the output is not stalled; the path is
// 8 front stages, a 32-stage divider, 2 back stages and the output register;
// the divider sets the depth: one quotient bit per stage
// the whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, nothing is lost or repeated
// reset clears valid bits and calibration registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module env_sensor_compensation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // adc_temp, adc_press, adc_hum
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // temperature_centi, pressure_pa, humidity_q10, pad
   output logic         rsp_tuser,   // pressure_invalid
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [esc_pkg::CsrIdxW-1:0] csr_index,
   input  logic [63:0]  csr_data
);
   import esc_pkg::*;

   // calibration registers
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff;
   logic [15:0] cal_press_c_ff;
   logic [39:0] cal_hum_a_ff;
   logic [31:0] cal_hum_b_ff;
   cal_type     cal;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
         cal_hum_a_ff   <= '0;
         cal_hum_b_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_data[47:0];
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_data;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_data;
            CSR_CAL_PRESS_C: cal_press_c_ff <= csr_data[15:0];
            CSR_CAL_HUM_A:   cal_hum_a_ff   <= csr_data[39:0];
            CSR_CAL_HUM_B:   cal_hum_b_ff   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // unpack coefficients, sign or zero extended
   always_comb begin
      cal.t1 = 32'(cal_temp_ff[15:0]);
      cal.t2 = 32'($signed(cal_temp_ff[31:16]));
      cal.t3 = 32'($signed(cal_temp_ff[47:32]));
      cal.p1 = 32'(cal_press_a_ff[15:0]);
      cal.p2 = 32'($signed(cal_press_a_ff[31:16]));
      cal.p3 = 32'($signed(cal_press_a_ff[47:32]));
      cal.p4 = 32'($signed(cal_press_a_ff[63:48]));
      cal.p5 = 32'($signed(cal_press_b_ff[15:0]));
      cal.p6 = 32'($signed(cal_press_b_ff[31:16]));
      cal.p7 = 32'($signed(cal_press_b_ff[47:32]));
      cal.p8 = 32'($signed(cal_press_b_ff[63:48]));
      cal.p9 = 32'($signed(cal_press_c_ff));
      cal.h1 = 32'(cal_hum_a_ff[7:0]);
      cal.h2 = 32'($signed(cal_hum_a_ff[23:8]));
      cal.h3 = 32'(cal_hum_a_ff[31:24]);
      cal.h6 = 32'($signed(cal_hum_a_ff[39:32]));
      cal.h4 = 32'($signed(cal_hum_b_ff[15:0]));
      cal.h5 = 32'($signed(cal_hum_b_ff[31:16]));
   end

   // global advance: output slot empty or being taken
   logic adv;
   logic out_v_ff;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   // front stages
   logic        f_v, f_hi, f_bad;
   logic [31:0] f_temp, f_num, f_den;
   logic [16:0] f_hum;
   esc_front u_front (
      .clock, .reset, .adv,
      .in_valid  (req_tvalid),
      .adc_temp  (req_tdata[19:0]),
      .adc_press (req_tdata[39:20]),
      .adc_hum   (req_tdata[55:40]),
      .cal,
      .out_valid (f_v),
      .out_temp  (f_temp),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_hi    (f_hi),
      .out_bad   (f_bad),
      .out_hum   (f_hum)
   );

   // divider; side data rides along as a tag
   localparam int unsigned TagW = 32 + 17 + 2;
   logic            d_v;
   logic [31:0]     d_quo;
   logic [TagW-1:0] d_tag;
   esc_div #(.TagW(TagW)) u_div (
      .clock, .reset, .adv,
      .in_valid  (f_v),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_tag    ({f_hi, f_bad, f_hum, f_temp}),
      .out_valid (d_v),
      .out_quo   (d_quo),
      .out_tag   (d_tag)
   );

   // back stages
   logic        b_v, b_bad;
   logic [31:0] b_temp, b_press;
   logic [16:0] b_hum;
   esc_back u_back (
      .clock, .reset, .adv,
      .in_valid  (d_v),
      .in_quo    (d_quo),
      .in_hi     (d_tag[50]),
      .in_bad    (d_tag[49]),
      .in_temp   (d_tag[31:0]),
      .in_hum    (d_tag[48:32]),
      .cal,
      .out_valid (b_v),
      .out_temp  (b_temp),
      .out_press (b_press),
      .out_hum   (b_hum),
      .out_bad   (b_bad)
   );

   // output register
   logic [87:0] out_data_ff;
   logic        out_user_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= b_v;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {7'd0, b_hum, b_press, b_temp};
         out_user_ff <= b_bad;
      end
   end
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // a stalled result holds
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                rsp_tvalid && $stable(rsp_tdata))
   // invalid pressure is reported as zero
   `ASSERT_IMPL(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser,
                rsp_tdata[63:32] == 32'd0)
   // humidity never above full scale
   `ASSERT_IMPL(a_hum_max, clock, reset, rsp_tvalid, rsp_tdata[80:64] <= 17'd102400)
endmodule

### rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// pipelined unsigned 32 by 32 restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module esc_div #(
   parameter int unsigned TagW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [31:0]     in_num,
   input  logic [31:0]     in_den,
   input  logic [TagW-1:0] in_tag,
   output logic            out_valid,
   output logic [31:0]     out_quo,
   output logic [TagW-1:0] out_tag
);
   localparam int unsigned N = 32;

   logic [N:1]       v_ff;
   logic [31:0]      rem_ff [1:N];
   logic [31:0]      num_ff [1:N];
   logic [31:0]      den_ff [1:N];
   logic [TagW-1:0]  tag_ff [1:N];

   for (genvar s = 0; s < N; s++) begin : g_st
      logic [31:0]     rem_s, num_s, den_s;
      logic [TagW-1:0] tag_s;
      logic [32:0]     r_in;
      logic [32:0]     d_in;
      // first stage takes the operands straight from the input
      if (s == 0) begin : g_head
         assign rem_s = '0;
         assign num_s = in_num;
         assign den_s = in_den;
         assign tag_s = in_tag;
      end else begin : g_body
         assign rem_s = rem_ff[s];
         assign num_s = num_ff[s];
         assign den_s = den_ff[s];
         assign tag_s = tag_ff[s];
      end
      always_comb begin
         r_in = {rem_s, num_s[N-1]};
         d_in = r_in - {1'b0, den_s};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= d_in[32] ? r_in[31:0] : d_in[31:0];
            num_ff[s+1] <= {num_s[N-2:0], ~d_in[32]};
            den_ff[s+1] <= den_s;
            tag_ff[s+1] <= tag_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[N-1:1], in_valid};
      end
   end
   assign out_valid = v_ff[N];
   assign out_quo   = num_ff[N];
   assign out_tag   = tag_ff[N];
endmodule

### rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// temperature, pressure divisor/dividend and humidity stages before the divide
// ----------------------------------------------------------------------------
module esc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [19:0]     adc_temp,
   input  logic [19:0]     adc_press,
   input  logic [15:0]     adc_hum,
   input  esc_pkg::cal_type cal,
   output logic            out_valid,
   output logic [31:0]     out_temp,
   output logic [31:0]     out_num,
   output logic [31:0]     out_den,
   output logic            out_hi,
   output logic            out_bad,
   output logic [16:0]     out_hum
);
   import esc_pkg::*;

   // stage 1: temperature products
   logic        v1_ff;
   logic [31:0] ta_ff, td2_ff, ap1_ff;
   logic [15:0] ah1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ta_ff  <= asr(mul32(32'(adc_temp >> 3) - (cal.t1 << 1), cal.t2), 11);
         td2_ff <= asr(mul32(32'(adc_temp >> 4) - cal.t1, 32'(adc_temp >> 4) - cal.t1), 12);
         ap1_ff <= 32'(adc_press);
         ah1_ff <= adc_hum;
      end
   end

   // stage 2: fine temperature
   logic        v2_ff;
   logic [31:0] fine_ff, ap2_ff;
   logic [15:0] ah2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         fine_ff <= ta_ff + asr(mul32(td2_ff, cal.t3), 14);
         ap2_ff  <= ap1_ff;
         ah2_ff  <= ah1_ff;
      end
   end

   // stage 3: first-level products
   logic        v3_ff;
   logic [31:0] temp3_ff, qq_ff, ap3_ff, p5a_ff, p2a_ff;
   logic [31:0] hy_ff, hz_ff, hx_ff;
   logic [31:0] s3_a, s3_q, s3_v;
   always_comb begin
      s3_a = asr(fine_ff, 1) - K64000;
      s3_q = asr(s3_a, 2);
      s3_v = fine_ff - K76800;
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         temp3_ff <= asr(mul32(fine_ff, 32'd5) + 32'd128, 8);
         qq_ff    <= mul32(s3_q, s3_q);
         p5a_ff   <= mul32(s3_a, cal.p5) << 1;
         p2a_ff   <= asr(mul32(cal.p2, s3_a), 1);
         ap3_ff   <= ap2_ff;
         hy_ff    <= asr(mul32(s3_v, cal.h6), 10);
         hz_ff    <= asr(mul32(s3_v, cal.h3), 11) + K32768;
         hx_ff    <= (32'(ah2_ff) << 14) - (cal.h4 << 20) - mul32(cal.h5, s3_v) + K16384;
      end
   end

   // stage 4: second-level products
   logic        v4_ff;
   logic [31:0] temp4_ff, b4_ff, a4_ff, ap4_ff, hx4_ff, hw4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         temp4_ff <= temp3_ff;
         b4_ff    <= asr(mul32(asr(qq_ff, 11), cal.p6) + p5a_ff, 2) + (cal.p4 << 16);
         a4_ff    <= asr(asr(mul32(cal.p3, asr(qq_ff, 13)), 3) + p2a_ff, 18);
         ap4_ff   <= ap3_ff;
         hx4_ff   <= asr(hx_ff, 15);
         hw4_ff   <= asr(mul32(hy_ff, hz_ff), 10) + K2097152;
      end
   end

   // stage 5: divisor and dividend, humidity w
   logic        v5_ff;
   logic [31:0] temp5_ff, div5_ff, pr5_ff, hx5_ff, hw5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         temp5_ff <= temp4_ff;
         div5_ff  <= asr(mul32(K32768 + a4_ff, cal.p1), 15);
         pr5_ff   <= mul32((K1M - ap4_ff) - asr(b4_ff, 12), K3125);
         hx5_ff   <= hx4_ff;
         hw5_ff   <= asr(mul32(hw4_ff, cal.h2) + K8192, 14);
      end
   end

   // stage 6: humidity x*w
   logic        v6_ff;
   logic [31:0] temp6_ff, div6_ff, pr6_ff, hv6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         temp6_ff <= temp5_ff;
         div6_ff  <= div5_ff;
         pr6_ff   <= pr5_ff;
         hv6_ff   <= mul32(hx5_ff, hw5_ff);
      end
   end

   // stage 7: q*q
   logic        v7_ff;
   logic [31:0] temp7_ff, div7_ff, pr7_ff, hv7_ff, hqq7_ff;
   logic [31:0] s7_q;
   assign s7_q = asr(hv6_ff, 15);
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         temp7_ff <= temp6_ff;
         div7_ff  <= div6_ff;
         pr7_ff   <= pr6_ff;
         hv7_ff   <= hv6_ff;
         hqq7_ff  <= asr(mul32(s7_q, s7_q), 7);
      end
   end

   // stage 8: humidity finish and clamp, divider operands and invalid flag
   logic        v8_ff;
   logic [31:0] s8_v;
   always_comb begin
      s8_v = hv7_ff - asr(mul32(hqq7_ff, cal.h1), 4);
      if ($signed(s8_v) < 0) s8_v = '0;
      if ($signed(KHUMMAX) < $signed(s8_v)) s8_v = KHUMMAX;
   end
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_temp <= temp7_ff;
         out_den  <= div7_ff;
         out_bad  <= (div7_ff == '0);
         out_hi   <= (pr7_ff >= KSIGN);
         out_num  <= (pr7_ff >= KSIGN) ? pr7_ff : (pr7_ff << 1);
         out_hum  <= s8_v[28:12];
      end
   end
   assign out_valid = v8_ff;
endmodule

### rtl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// pressure correction stages after the divide
// ----------------------------------------------------------------------------
module esc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [31:0]      in_quo,
   input  logic             in_hi,
   input  logic             in_bad,
   input  logic [31:0]      in_temp,
   input  logic [16:0]      in_hum,
   input  esc_pkg::cal_type cal,
   output logic             out_valid,
   output logic [31:0]      out_temp,
   output logic [31:0]      out_press,
   output logic [16:0]      out_hum,
   output logic             out_bad
);
   import esc_pkg::*;

   // stage 1: q*q and press*p8
   logic        v1_ff, bad1_ff;
   logic [31:0] pr1_ff, qq1_ff, b1_ff, t1_ff;
   logic [16:0] h1_ff;
   logic [31:0] s1_p, s1_q;
   always_comb begin
      s1_p = in_hi ? (in_quo << 1) : in_quo;
      s1_q = s1_p >> 3;
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pr1_ff  <= s1_p;
         qq1_ff  <= mul32(s1_q, s1_q) >> 13;
         b1_ff   <= asr(mul32(s1_p >> 2, cal.p8), 13);
         bad1_ff <= in_bad;
         t1_ff   <= in_temp;
         h1_ff   <= in_hum;
      end
   end

   // stage 2: p9 product and final sum
   logic        v2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_press <= bad1_ff ? '0 :
            pr1_ff + asr(asr(mul32(cal.p9, qq1_ff), 12) + b1_ff + cal.p7, 4);
         out_bad   <= bad1_ff;
         out_temp  <= t1_ff;
         out_hum   <= h1_ff;
      end
   end
   assign out_valid = v2_ff;
endmodule
